[hdl/iir_direct_form_one_filter_macros.svh]
// Assertion shorthands for the IIR filter; each samples on clk and
// is disabled while rst_n is low.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// Condition and consequence in the same cycle.
`define IIRDF1_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define IIRDF1_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[hdl/iirdf1_pkg.sv]
package iirdf1_pkg;

    localparam int TAPS_DEFAULT       = 13;
    localparam int COEF_FRAC_DEFAULT  = 31;
    localparam int OUT_FRAC_DEFAULT   = 16;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 17;
    localparam int INDEX_W  = 4;
    localparam int COEF_W   = 40;
    localparam int OUT_W    = 40;
    // operand split for the shared multiplier: two 20-bit chunks per 40-bit word
    localparam int CHUNK_W  = 20;
    localparam int MUL_W    = CHUNK_W + 1;
    localparam int PROD_W   = 2 * MUL_W;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_WRITE_A = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [INDEX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]    coef_value;
    } feed_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    saturated;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_SAT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DATA_LO,
        DATA_HI,
        DATA_ALL
    } data_sel_t;

    typedef enum logic [2:0] {
        SHIFT_NONE,
        SHIFT_ONE_CHUNK,
        SHIFT_TWO_CHUNK,
        SHIFT_SCALE,
        SHIFT_SCALE_CHUNK
    } shift_sel_t;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       issue;
        logic       coef_hi;
        data_sel_t  data_sel;
        shift_sel_t shift;
        logic       sub;
        logic       round;
    } mac_ctl_t;

    typedef struct packed {
        logic wr_b;
        logic wr_a;
        logic push_x;
        logic push_y;
        logic clear;
    } store_cmd_t;

endpackage

[hdl/iirdf1_stream_if.sv]
interface iirdf1_feed_if
    import iirdf1_pkg::*;
();
    logic       valid;
    logic       ready;
    feed_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iirdf1_result_if
    import iirdf1_pkg::*;
();
    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/iirdf1_mac.sv]
module iirdf1_mac
    import iirdf1_pkg::*;
#(
    parameter int TAPS           = TAPS_DEFAULT,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [COEF_W-1:0] data,
    output logic signed [OUT_W-1:0]  y,
    output logic                     sat
);

    // exact sum of up to 2*TAPS products of at most 80 bits
    localparam int ACC_W = 81 + $clog2(2 * TAPS);
    localparam int TOP_LSB = COEF_FRAC_BITS + OUT_W - 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [OUT_W-1:0] Y_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] Y_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [COEF_W-1:0] op_coef_reg;
    logic signed [COEF_W-1:0] op_data_reg;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_sub_reg;
    shift_sel_t               prod_shift_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-TOP_LSB-1:0] acc_top;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_coef_reg <= coef;
            op_data_reg <= data;
        end
    end

    // upper chunks carry the sign, lower chunks are plain magnitudes
    always_comb
    begin
        if (ctl.coef_hi)
            mul_a = MUL_W'($signed(op_coef_reg[COEF_W-1:CHUNK_W]));
        else
            mul_a = {1'b0, op_coef_reg[CHUNK_W-1:0]};
        case (ctl.data_sel)
            DATA_HI:  mul_b = MUL_W'($signed(op_data_reg[COEF_W-1:CHUNK_W]));
            DATA_ALL: mul_b = op_data_reg[MUL_W-1:0];
            default:  mul_b = {1'b0, op_data_reg[CHUNK_W-1:0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= ctl.issue;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg       <= mul_a * mul_b;
            prod_sub_reg   <= ctl.sub;
            prod_shift_reg <= ctl.shift;
        end
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        case (prod_shift_reg)
            SHIFT_ONE_CHUNK:   addend = prod_ext <<< CHUNK_W;
            SHIFT_TWO_CHUNK:   addend = prod_ext <<< (2 * CHUNK_W);
            SHIFT_SCALE:       addend = prod_ext <<< OUT_FRAC_BITS;
            SHIFT_SCALE_CHUNK: addend = prod_ext <<< (OUT_FRAC_BITS + CHUNK_W);
            default:           addend = prod_ext;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= prod_sub_reg ? acc_reg - addend : acc_reg + addend;
        else if (ctl.round)
            acc_reg <= acc_reg + ROUND_HALF;
    end

    // clip when the bits above the output field are not a plain sign extension
    assign acc_top = acc_reg[ACC_W-1:TOP_LSB];
    assign sat     = !((&acc_top) || !(|acc_top));
    assign y       = sat ? (acc_reg[ACC_W-1] ? Y_MIN : Y_MAX)
                         : acc_reg[TOP_LSB:COEF_FRAC_BITS];

endmodule

[hdl/iirdf1_store.sv]
module iirdf1_store
    import iirdf1_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT,
    localparam int TAP_W = $clog2(TAPS)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  store_cmd_t               cmd,
    input  logic [TAP_W-1:0]         wr_tap,
    input  logic signed [COEF_W-1:0] wr_coef,
    input  logic signed [DIFF_W-1:0] push_diff,
    input  logic signed [OUT_W-1:0]  push_y,
    input  logic                     rd_fb,
    input  logic [TAP_W-1:0]         rd_tap,
    output logic signed [COEF_W-1:0] rd_coef,
    output logic signed [COEF_W-1:0] rd_data
);

    localparam int OH_DEPTH = TAPS - 1;
    localparam int OH_W     = (TAPS > 2) ? $clog2(TAPS - 1) : 1;

    logic signed [COEF_W-1:0] b_coef [TAPS];
    logic signed [COEF_W-1:0] a_coef [TAPS];
    logic signed [DIFF_W-1:0] in_hist [TAPS];
    logic signed [OUT_W-1:0]  out_hist [OH_DEPTH];
    logic [OH_W-1:0]          oh_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            b_coef[wr_tap] <= wr_coef;
        if (cmd.wr_a)
            a_coef[wr_tap] <= wr_coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                in_hist[i] <= '0;
            for (int i = 0; i < OH_DEPTH; i++)
                out_hist[i] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < TAPS; i++)
                in_hist[i] <= '0;
            for (int i = 0; i < OH_DEPTH; i++)
                out_hist[i] <= '0;
        end
        else
        begin
            if (cmd.push_x)
            begin
                in_hist[0] <= push_diff;
                for (int i = 1; i < TAPS; i++)
                    in_hist[i] <= in_hist[i-1];
            end
            if (cmd.push_y)
            begin
                out_hist[0] <= push_y;
                for (int i = 1; i < OH_DEPTH; i++)
                    out_hist[i] <= out_hist[i-1];
            end
        end
    end

    // feedback tap k pairs with the output delayed by k samples
    assign oh_idx  = OH_W'(rd_tap - 1'b1);
    assign rd_coef = rd_fb ? a_coef[rd_tap] : b_coef[rd_tap];
    assign rd_data = rd_fb ? out_hist[oh_idx] : COEF_W'(in_hist[rd_tap]);

endmodule

[hdl/iir_direct_form_one_filter.sv]
// Channel  | Modport | Payload                                    | Transaction
// ---------+---------+--------------------------------------------+---------------------------
// feed     | sink    | opcode, sample, coef_index, coef_value     | one command or sample
// result   | source  | filtered, saturated                        | one output per sample
//
// A sample holds the block from acceptance until its output step, and no new item
// is taken meanwhile: one shared 21x21 multiplier takes two partial products per
// feedforward tap and four per feedback tap, plus load, drain, round, clip, output
// and idle steps. The result is registered in the output step.
// Coefficient writes and restart are taken in the idle step, which stays ready.
// Reset (rst_n low, asynchronous) clears histories, arms the baseline capture
// and empties the result register; coefficients are undefined until written.
// A stalled result holds in its register; a new item is accepted meanwhile,
// and a following sample waits at its end until the register is free.
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int TAPS           = TAPS_DEFAULT,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEFAULT,
    parameter int OUT_FRAC_BITS  = OUT_FRAC_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    iirdf1_feed_if.sink             feed,
    iirdf1_result_if.source         result
);

`include "iir_direct_form_one_filter_macros.svh"

    localparam int TAP_W = $clog2(TAPS);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    // sequencer state
    state_t                     state_reg, state_next;
    logic [TAP_W-1:0]           tap_reg, tap_next;
    logic                       fb_reg, fb_next;
    logic [1:0]                 part_reg, part_next;
    logic                       armed_reg, armed_next;
    logic signed [SAMPLE_W-1:0] base_reg, base_next;

    // finished output, waiting for the result register
    logic signed [OUT_W-1:0]    y_reg, y_next;
    logic                       sat_reg, sat_next;

    // result register
    logic                       res_valid_reg;
    result_item_t               res_data_reg;
    logic                       res_load;

    logic                       accept;
    logic                       idx_ok;
    logic                       last_part;
    logic signed [DIFF_W-1:0]   diff;

    mac_ctl_t                   mac_ctl;
    store_cmd_t                 store_cmd;
    logic                       rd_fb;
    logic [TAP_W-1:0]           rd_tap;
    logic signed [COEF_W-1:0]   rd_coef;
    logic signed [COEF_W-1:0]   rd_data;
    logic signed [OUT_W-1:0]    mac_y;
    logic                       mac_sat;

    assign accept = feed.valid && feed.ready;
    assign idx_ok = (32'(feed.data.coef_index) < TAPS);

    // The first sample after reset or restart is its own baseline: difference zero.
    assign diff = DIFF_W'(feed.data.sample)
                - (armed_reg ? DIFF_W'(feed.data.sample) : DIFF_W'(base_reg));

    // Feedforward terms take two partial products, feedback terms four.
    assign last_part = fb_reg ? (part_reg == 2'd3) : (part_reg == 2'd1);

    iirdf1_store #(
        .TAPS (TAPS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (store_cmd),
        .wr_tap    (TAP_W'(feed.data.coef_index)),
        .wr_coef   (feed.data.coef_value),
        .push_diff (diff),
        .push_y    (mac_y),
        .rd_fb     (rd_fb),
        .rd_tap    (rd_tap),
        .rd_coef   (rd_coef),
        .rd_data   (rd_data)
    );

    iirdf1_mac #(
        .TAPS           (TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (rd_coef),
        .data  (rd_data),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            fb_reg    <= 1'b0;
            part_reg  <= '0;
            armed_reg <= 1'b1;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            fb_reg    <= fb_next;
            part_reg  <= part_next;
            armed_reg <= armed_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        sat_reg <= sat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        fb_next    = fb_reg;
        part_next  = part_reg;
        armed_next = armed_reg;
        base_next  = base_reg;
        y_next     = y_reg;
        sat_next   = sat_reg;
        feed.ready = 1'b0;
        res_load   = 1'b0;
        rd_fb      = fb_reg;
        rd_tap     = tap_reg;
        store_cmd  = '0;
        mac_ctl    = '0;
        mac_ctl.data_sel = DATA_ALL;
        mac_ctl.shift    = SHIFT_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                feed.ready = 1'b1;
                if (feed.valid)
                begin
                    unique case (feed.data.opcode)
                        OP_SAMPLE:
                        begin
                            // capture the baseline when armed, push the difference, start over
                            store_cmd.push_x = 1'b1;
                            if (armed_reg)
                                base_next = feed.data.sample;
                            armed_next    = 1'b0;
                            mac_ctl.clear = 1'b1;
                            tap_next      = '0;
                            fb_next       = 1'b0;
                            part_next     = '0;
                            state_next    = ST_LOAD;
                        end
                        OP_WRITE_B:
                            store_cmd.wr_b = idx_ok;
                        OP_WRITE_A:
                            store_cmd.wr_a = idx_ok;
                        OP_RESTART:
                        begin
                            store_cmd.clear = 1'b1;
                            armed_next      = 1'b1;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                // fetch operands of the first feedforward tap
                rd_fb         = 1'b0;
                rd_tap        = '0;
                mac_ctl.load  = 1'b1;
                state_next    = ST_MAC;
            end

            ST_MAC:
            begin
                mac_ctl.issue = 1'b1;
                if (!fb_reg)
                begin
                    mac_ctl.coef_hi  = part_reg[0];
                    mac_ctl.data_sel = DATA_ALL;
                    mac_ctl.shift    = part_reg[0] ? SHIFT_SCALE_CHUNK : SHIFT_SCALE;
                end
                else
                begin
                    mac_ctl.sub      = 1'b1;
                    mac_ctl.coef_hi  = part_reg[1];
                    mac_ctl.data_sel = part_reg[0] ? DATA_HI : DATA_LO;
                    case (part_reg) inside
                        2'd0:       mac_ctl.shift = SHIFT_NONE;
                        2'd1, 2'd2: mac_ctl.shift = SHIFT_ONE_CHUNK;
                        default:    mac_ctl.shift = SHIFT_TWO_CHUNK;
                    endcase
                end

                if (!last_part)
                    part_next = part_reg + 2'd1;
                else
                begin
                    part_next = '0;
                    if (fb_reg && (tap_reg == LAST_TAP))
                        state_next = ST_DRAIN;
                    else
                    begin
                        // advance to the next term and fetch its operands
                        if (!fb_reg && (tap_reg == LAST_TAP))
                        begin
                            fb_next  = 1'b1;
                            tap_next = TAP_W'(1);
                        end
                        else
                            tap_next = TAP_W'(tap_reg + 1'b1);
                        rd_fb        = fb_next;
                        rd_tap       = tap_next;
                        mac_ctl.load = 1'b1;
                    end
                end
            end

            ST_DRAIN:
                // last partial product enters the accumulator
                state_next = ST_ROUND;

            ST_ROUND:
            begin
                mac_ctl.round = 1'b1;
                state_next    = ST_SAT;
            end

            ST_SAT:
            begin
                store_cmd.push_y = 1'b1;
                y_next           = mac_y;
                sat_next         = mac_sat;
                state_next       = ST_OUT;
            end

            ST_OUT:
            begin
                // hold until the result register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg.filtered  <= y_reg;
            res_data_reg.saturated <= sat_reg;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // A result appears only from the output step of the sequencer.
    `IIRDF1_ASSERT_NOW(a_result_from_out, $rose(result.valid), $past(state_reg == ST_OUT), "result valid rose outside the output step")

    // An accepted sample always starts the operand fetch.
    `IIRDF1_ASSERT_NEXT(a_sample_starts, accept && (feed.data.opcode == OP_SAMPLE), state_reg == ST_LOAD, "sample did not start the multiply-accumulate sequence")

    // A waiting result is never overwritten by the next one.
    `IIRDF1_ASSERT_NEXT(a_out_waits, (state_reg == ST_OUT) && result.valid && !result.ready, state_reg == ST_OUT, "pending result overwritten")

endmodule

[tb/sv/iir_direct_form_one_filter_test.sv]
`timescale 1ns / 1ps

module iir_direct_form_one_filter_test;
    import iirdf1_pkg::*;

    localparam int TAPS      = TAPS_DEFAULT;
    localparam int COEF_FRAC = COEF_FRAC_DEFAULT;
    localparam int OUT_FRAC  = OUT_FRAC_DEFAULT;

    // Extra wait after the last expected output, to catch stray outputs.
    localparam int DRAIN_CYCLES = 6 * TAPS + 40;
    // Slowest correct run is roughly 1800 transactions;
    // the watchdog allows several times its length.
    localparam int WATCHDOG_CYCLES = 2_000_000;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 40'sh00_8000_0000;  // 1.0 in Q9.31
    localparam logic signed [COEF_W-1:0] COEF_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 40'sh80_0000_0000;
    localparam logic signed [OUT_W-1:0]  OUT_MAX  = 40'sh7F_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0]  OUT_MIN  = 40'sh80_0000_0000;
    localparam logic signed [127:0]      ACC_HI   = (128'sd1 <<< (OUT_W - 1)) - 1;
    localparam logic signed [127:0]      ACC_LO   = -(128'sd1 <<< (OUT_W - 1));

    // Coefficient sets used by the random traffic.
    typedef enum
    {
        STYLE_WIDE,       // full 40-bit random, clips almost always
        STYLE_DAMPED,     // small random taps, sum of feedback |a| at most 0.75
        STYLE_SMOOTHING,  // fixed symmetric taps with light feedback
        STYLE_DELAY       // a single unit tap, output is a delayed copy
    } coef_style_t;

    logic clk;
    logic rst_n;

    iirdf1_feed_if   feed_ch ();
    iirdf1_result_if result_ch ();

    iir_direct_form_one_filter u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch)
    );

    // Shadow copy of the filter state, advanced on every accepted transaction.
    logic                        base_armed = 1'b1;
    logic signed [SAMPLE_W-1:0]  base_sample = '0;
    logic signed [DIFF_W-1:0]    x_taps [TAPS];
    logic signed [OUT_W-1:0]     y_taps [TAPS-1];
    logic signed [COEF_W-1:0]    b_coefs [TAPS];
    logic signed [COEF_W-1:0]    a_coefs [TAPS];

    result_item_t expected_outputs [$];
    result_item_t popped_output;

    real smooth_taps [7] = '{0.00188432874045137, -0.0113059724427082, 0.0282649311067706,
                             -0.0376865748090275, 0.0282649311067706, -0.0113059724427082,
                             0.00188432874045137};

    int feed_gap_pct;
    int output_stall_pct;
    int cycle_count;
    int n_items;
    int n_samples;
    int n_clipped;
    int n_coef_writes;
    int n_ignored_writes;
    int n_restarts;
    int n_outputs;
    int n_errors;

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: bail out if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > WATCHDOG_CYCLES)
        begin
            $display("%0t: watchdog expired with %0d outputs still pending", $time,
                     expected_outputs.size());
            $display("** iir_direct_form_one_filter: FAILED **");
            $finish;
        end
    end

    // Output backpressure: drop ready at random for the configured share of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(99) >= output_stall_pct);
    end

    // Compare every output transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected output filtered=%h saturated=%b", $time,
                         result_ch.data.filtered, result_ch.data.saturated);
                n_errors++;
            end
            else
            begin
                popped_output = expected_outputs.pop_front();
                if (result_ch.data.filtered !== popped_output.filtered)
                begin
                    $display("%0t: filtered mismatch, expected %h actual %h", $time,
                             popped_output.filtered, result_ch.data.filtered);
                    n_errors++;
                end
                if (result_ch.data.saturated !== popped_output.saturated)
                begin
                    $display("%0t: saturated mismatch, expected %b actual %b", $time,
                             popped_output.saturated, result_ch.data.saturated);
                    n_errors++;
                end
                n_outputs++;
            end
        end
    end

    function automatic logic signed [COEF_W-1:0] to_q31(input real value);
        return 40'(longint'(value * 2147483648.0));
    endfunction

    // Signed random value spanning bits bits (bits <= 40).
    function automatic logic signed [COEF_W-1:0] rand_span(input int bits);
        logic signed [63:0] raw;
        raw = {$urandom, $urandom};
        return 40'(raw >>> (64 - bits));
    endfunction

    // Advance the shadow filter by one accepted transaction; queue the output
    // that a sample produces.
    task automatic advance_filter_model(input feed_item_t item);
        logic signed [127:0] acc;
        logic signed [127:0] coef_w;
        logic signed [127:0] data_w;
        result_item_t        out_item;
        int                  i;
        case (item.opcode)
            OP_WRITE_B, OP_WRITE_A:
            begin
                if (item.coef_index < TAPS)
                begin
                    if (item.opcode == OP_WRITE_B)
                        b_coefs[item.coef_index] = item.coef_value;
                    else
                        a_coefs[item.coef_index] = item.coef_value;
                    n_coef_writes++;
                end
                else
                    n_ignored_writes++;
            end
            OP_RESTART:
            begin
                for (i = 0; i < TAPS; i++)
                    x_taps[i] = '0;
                for (i = 0; i < TAPS - 1; i++)
                    y_taps[i] = '0;
                base_armed = 1'b1;
                n_restarts++;
            end
            OP_SAMPLE:
            begin
                if (base_armed)
                begin
                    base_sample = item.sample;
                    base_armed  = 1'b0;
                end
                for (i = TAPS - 1; i > 0; i--)
                    x_taps[i] = x_taps[i-1];
                x_taps[0] = $signed(item.sample) - $signed(base_sample);

                // Exact sum at COEF_FRAC + OUT_FRAC fraction bits.
                acc = '0;
                for (i = 0; i < TAPS; i++)
                begin
                    coef_w = b_coefs[i];
                    data_w = x_taps[i];
                    acc = acc + coef_w * (data_w <<< OUT_FRAC);
                end
                for (i = 1; i < TAPS; i++)
                begin
                    coef_w = a_coefs[i];
                    data_w = y_taps[i-1];
                    acc = acc - coef_w * data_w;
                end
                // Round half up, then clip to the output range.
                acc = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
                out_item.saturated = 1'b1;
                if (acc > ACC_HI)
                    out_item.filtered = OUT_MAX;
                else if (acc < ACC_LO)
                    out_item.filtered = OUT_MIN;
                else
                begin
                    out_item.filtered  = acc[OUT_W-1:0];
                    out_item.saturated = 1'b0;
                end

                for (i = TAPS - 2; i > 0; i--)
                    y_taps[i] = y_taps[i-1];
                y_taps[0] = out_item.filtered;
                expected_outputs.push_back(out_item);
                n_samples++;
                if (out_item.saturated)
                    n_clipped++;
            end
        endcase
    endtask

    // Present one transaction on the feed channel, idle first if the dice say so,
    // and hold it until the block takes it.
    task automatic send_item(input feed_item_t item);
        while ($urandom_range(99) < feed_gap_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        feed_ch.valid <= 1'b1;
        feed_ch.data  <= item;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        advance_filter_model(item);
        n_items++;
    endtask

    // Unused fields carry random content so every bit toggles.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        feed_item_t item;
        item.opcode     = OP_SAMPLE;
        item.sample     = value;
        item.coef_index = 4'($urandom);
        item.coef_value = rand_span(COEF_W);
        send_item(item);
    endtask

    task automatic send_coef(input opcode_t op, input int index,
                             input logic signed [COEF_W-1:0] value);
        feed_item_t item;
        item.opcode     = op;
        item.sample     = 16'($urandom);
        item.coef_index = 4'(index);
        item.coef_value = value;
        send_item(item);
    endtask

    task automatic send_restart();
        feed_item_t item;
        item.opcode     = OP_RESTART;
        item.sample     = 16'($urandom);
        item.coef_index = 4'($urandom);
        item.coef_value = rand_span(COEF_W);
        send_item(item);
    endtask

    // Write every b and a tap, a[0] included, for the chosen style.
    task automatic load_coef_set(input coef_style_t style, input int delay_tap);
        logic signed [COEF_W-1:0] b_val;
        logic signed [COEF_W-1:0] a_val;
        int                       i;
        for (i = 0; i < TAPS; i++)
        begin
            case (style)
                STYLE_WIDE:
                begin
                    b_val = rand_span(COEF_W);
                    a_val = rand_span(COEF_W);
                end
                STYLE_DAMPED:
                begin
                    b_val = rand_span(29);
                    a_val = rand_span(28);
                end
                STYLE_SMOOTHING:
                begin
                    b_val = (i < 7) ? to_q31(smooth_taps[i]) : '0;
                    a_val = (i == 1) ? to_q31(-0.5) :
                            (i == 2) ? to_q31(0.0283414576932032) : '0;
                end
                default:
                begin
                    b_val = (i == delay_tap) ? COEF_ONE : '0;
                    a_val = '0;
                end
            endcase
            // a[0] is stored but never enters the sum; give it something loud.
            if (i == 0)
                a_val = to_q31(-131.100753923188);
            send_coef(OP_WRITE_B, i, b_val);
            send_coef(OP_WRITE_A, i, a_val);
        end
    endtask

    // Every tap must be written before the first sample reads it.
    task automatic test_coefficient_load();
        load_coef_set(STYLE_DELAY, 0);
    endtask

    // Drive the accumulator far past both output limits, through the
    // feedforward path and then through the feedback path.
    task automatic test_saturation_extremes();
        send_coef(OP_WRITE_B, 0, COEF_MAX);
        send_coef(OP_WRITE_B, 1, COEF_MIN);
        send_sample(-16'sd32768);   // baseline, output zero
        send_sample(16'sd32767);    // largest positive difference
        send_sample(-16'sd32768);   // difference moves to tap 1, clips low
        send_coef(OP_WRITE_A, 1, COEF_MAX);
        send_sample(16'sd0);
        send_sample(16'sd32767);
    endtask

    // With b[0] = 2^-17 a unit difference lands exactly on half an output LSB:
    // ties must go toward plus infinity on both signs.
    task automatic test_rounding_ties();
        send_coef(OP_WRITE_B, 0, 40'sd16384);
        send_coef(OP_WRITE_B, 1, '0);
        send_coef(OP_WRITE_A, 1, '0);
        send_restart();
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(-16'sd3);
        send_sample(16'sd2);
    endtask

    // Writes past the last tap must be dropped; a write to a[0] must not matter.
    task automatic test_ignored_writes();
        send_coef(OP_WRITE_B, 13, COEF_MAX);
        send_coef(OP_WRITE_A, 14, COEF_MIN);
        send_coef(OP_WRITE_B, 15, COEF_MIN);
        send_coef(OP_WRITE_A, 0, COEF_MAX);
        send_restart();
        send_sample(-16'sd7);
        send_sample(-16'sd6);
        send_sample(16'sd32767);
    endtask

    // Segments of samples, most under a fresh coefficient set, with restarts,
    // stray writes and out-of-range writes mixed in.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int count);
        coef_style_t             style;
        logic signed [SAMPLE_W-1:0] center;
        int                      stop_at;
        int                      seg_len;
        int                      pick;
        int                      j;
        feed_gap_pct     = gap_pct;
        output_stall_pct = stall_pct;
        stop_at          = n_items + count;
        while (n_items < stop_at)
        begin
            pick = $urandom_range(99);
            style = (pick < 40) ? STYLE_DAMPED :
                    (pick < 60) ? STYLE_SMOOTHING :
                    (pick < 80) ? STYLE_DELAY : STYLE_WIDE;
            if ($urandom_range(2) != 0)
                load_coef_set(style, $urandom_range(TAPS - 1));
            if ($urandom_range(1) != 0)
                send_restart();
            center  = 16'($urandom);
            seg_len = $urandom_range(30, 90);
            for (j = 0; j < seg_len && n_items < stop_at; j++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    send_restart();
                else if (pick < 6)
                    send_coef($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B,
                              $urandom_range(TAPS, 15), rand_span(COEF_W));
                else if (pick < 9)
                    send_coef($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B,
                              $urandom_range(TAPS - 1),
                              rand_span(style == STYLE_WIDE ? COEF_W : 26));
                // Mostly small moves around the segment's level, some full-scale.
                if ($urandom_range(3) == 0)
                    send_sample(16'($urandom));
                else
                    send_sample(16'(center + $urandom_range(127) - 64));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            x_taps[i]  = '0;
            b_coefs[i] = '0;
            a_coefs[i] = '0;
        end
        for (int i = 0; i < TAPS - 1; i++)
            y_taps[i] = '0;

        // Hold every input at a known level from time zero.
        clk              = 1'b0;
        rst_n            = 1'b0;
        feed_ch.valid    = 1'b0;
        feed_ch.data     = '0;
        result_ch.ready  = 1'b0;
        feed_gap_pct     = 30;
        output_stall_pct = 81;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coefficient_load();
        test_saturation_extremes();
        test_rounding_ties();
        test_ignored_writes();
        test_random_traffic(30, 81, 570);
        test_random_traffic(81, 30, 570);
        test_random_traffic(0, 0, 570);

        // Drop valid, drain the outstanding outputs, then watch for strays.
        feed_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions: %0d samples (%0d clipped), %0d tap writes, "
                 , n_items, n_samples, n_clipped, n_coef_writes);
        $display("%0d out-of-range writes, %0d restarts; %0d outputs checked, %0d mismatches",
                 n_ignored_writes, n_restarts, n_outputs, n_errors);
        if (n_errors == 0)
            $display("** iir_direct_form_one_filter: PASSED **");
        else
            $display("** iir_direct_form_one_filter: FAILED **");
        $finish;
    end

endmodule

[iir_direct_form_one_filter.f]
+incdir+hdl
hdl/iirdf1_pkg.sv
hdl/iirdf1_stream_if.sv
hdl/iirdf1_mac.sv
hdl/iirdf1_store.sv
hdl/iir_direct_form_one_filter.sv
tb/sv/iir_direct_form_one_filter_test.sv
